### src/qsl_pkg.sv
// ----------------------------------------------------------------------------
// qsl_pkg: shared types for the quicksort block
// Payload structs for the request and response channels, the datapath
// command codes and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package qsl_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      data_type value;
      logic     last;
   } req_payload_type;

   typedef struct packed {
      data_type sorted_value;
      logic     final_res;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_START,
      OP_POP,
      OP_RANGE,
      OP_PIVOT,
      OP_SCAN_RD,
      OP_CMP_HIT,
      OP_CMP_MISS,
      OP_SW1,
      OP_SW2,
      OP_FIN_RD,
      OP_FIN_W1,
      OP_FIN_W2,
      OP_PUSH_R,
      OP_PUSH_L,
      OP_EMIT_RD,
      OP_EMIT_LD,
      OP_DONE
   } op_type;

   typedef struct packed {
      logic stack_empty;
      logic range_ok;
      logic le;
      logic scan_done;
      logic emit_done;
      logic out_free;
   } stat_type;

endpackage

### src/qsl_dp.sv
// ----------------------------------------------------------------------------
// qsl_dp: quicksort datapath
// Element store, range stack, partition indexes, pivot and the response
// register. Each command from the controller performs one step.
// ----------------------------------------------------------------------------
module qsl_dp #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  qsl_pkg::op_type          op,
   input  qsl_pkg::req_payload_type req_payload,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output qsl_pkg::rsp_payload_type rsp_payload,
   output qsl_pkg::stat_type        stat
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);

   qsl_pkg::data_type elem_mem [MAX_ITEMS];
   logic [2*CW-1:0]   stack_mem [MAX_ITEMS];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] bnd_ff, bnd_in;
   qsl_pkg::data_type pivot_ff, pivot_in;
   qsl_pkg::data_type held_ff, held_in;
   qsl_pkg::data_type rdata_ff;
   logic [2*CW-1:0]   srdata_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   qsl_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic              we, re, sre, push;
   logic [AW-1:0]     waddr, raddr, sraddr;
   qsl_pkg::data_type wdata;
   logic [CW-1:0]     push_lo, push_hi;
   logic              push_ok;
   logic [CW-1:0]     pop_lo, pop_hi, pop_hi_m1, hi_m1;

   assign pop_lo    = srdata_ff[2*CW-1:CW];
   assign pop_hi    = srdata_ff[CW-1:0];
   assign pop_hi_m1 = pop_hi - 1'b1;
   assign hi_m1     = hi_ff - 1'b1;

   // Ranges shorter than two are already sorted and never go on the stack.
   assign push_ok = ({1'b0, push_lo} + 1'b1 < {1'b0, push_hi}) && (sp_ff < MaxCount);

   assign stat.stack_empty = (sp_ff == '0);
   assign stat.range_ok    = !(pop_hi > count_ff) &&
                             ({1'b0, pop_lo} + 1'b1 < {1'b0, pop_hi});
   assign stat.le          = (rdata_ff <= pivot_ff);
   assign stat.scan_done   = (scan_ff == hi_m1);
   assign stat.emit_done   = (k_ff == count_ff);
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      we           = 1'b0;
      re           = 1'b0;
      sre          = 1'b0;
      push         = 1'b0;
      waddr        = count_ff[AW-1:0];
      wdata        = req_payload.value;
      raddr        = scan_ff[AW-1:0];
      sraddr       = sp_ff[AW-1:0];
      push_lo      = lo_ff;
      push_hi      = hi_ff;
      count_in     = count_ff;
      sp_in        = sp_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      scan_in      = scan_ff;
      bnd_in       = bnd_ff;
      pivot_in     = pivot_ff;
      held_in      = held_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (op)
         qsl_pkg::OP_LOAD: begin
            if (count_ff < MaxCount) begin
               we       = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         qsl_pkg::OP_START: begin
            push_lo = '0;
            push_hi = count_ff;
            push    = 1'b1;
         end
         qsl_pkg::OP_POP: begin
            sp_in  = sp_ff - 1'b1;
            sre    = 1'b1;
            sraddr = sp_in[AW-1:0];
         end
         qsl_pkg::OP_RANGE: begin
            lo_in   = pop_lo;
            hi_in   = pop_hi;
            scan_in = pop_lo;
            bnd_in  = pop_lo;
            re      = 1'b1;
            raddr   = pop_hi_m1[AW-1:0];
         end
         qsl_pkg::OP_PIVOT: begin
            pivot_in = rdata_ff;
         end
         qsl_pkg::OP_SCAN_RD: begin
            re    = 1'b1;
            raddr = scan_ff[AW-1:0];
         end
         qsl_pkg::OP_CMP_HIT: begin
            held_in = rdata_ff;
            re      = 1'b1;
            raddr   = bnd_ff[AW-1:0];
         end
         qsl_pkg::OP_CMP_MISS: begin
            scan_in = scan_ff + 1'b1;
         end
         qsl_pkg::OP_SW1: begin
            we    = 1'b1;
            waddr = scan_ff[AW-1:0];
            wdata = rdata_ff;
         end
         qsl_pkg::OP_SW2: begin
            we      = 1'b1;
            waddr   = bnd_ff[AW-1:0];
            wdata   = held_ff;
            bnd_in  = bnd_ff + 1'b1;
            scan_in = scan_ff + 1'b1;
         end
         qsl_pkg::OP_FIN_RD: begin
            re    = 1'b1;
            raddr = bnd_ff[AW-1:0];
         end
         qsl_pkg::OP_FIN_W1: begin
            // The pivot slot still holds the pivot, so it takes the boundary value.
            we    = 1'b1;
            waddr = hi_m1[AW-1:0];
            wdata = rdata_ff;
         end
         qsl_pkg::OP_FIN_W2: begin
            we    = 1'b1;
            waddr = bnd_ff[AW-1:0];
            wdata = pivot_ff;
         end
         qsl_pkg::OP_PUSH_R: begin
            push_lo = bnd_ff + 1'b1;
            push_hi = hi_ff;
            push    = 1'b1;
         end
         qsl_pkg::OP_PUSH_L: begin
            push_lo = lo_ff;
            push_hi = bnd_ff;
            push    = 1'b1;
         end
         qsl_pkg::OP_EMIT_RD: begin
            re    = 1'b1;
            raddr = k_ff[AW-1:0];
         end
         qsl_pkg::OP_EMIT_LD: begin
            rsp_in.sorted_value = rdata_ff;
            rsp_in.final_res    = ({1'b0, k_ff} + 1'b1 == {1'b0, count_ff});
            rsp_valid_in        = 1'b1;
            k_in                = k_ff + 1'b1;
         end
         qsl_pkg::OP_DONE: begin
            count_in = '0;
            sp_in    = '0;
            k_in     = '0;
         end
         default: begin
         end
      endcase
      if (push && push_ok) begin
         sp_in = sp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         elem_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= elem_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_ok) begin
         stack_mem[sp_ff[AW-1:0]] <= {push_lo, push_hi};
      end
      if (sre) begin
         srdata_ff <= stack_mem[sraddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sp_ff        <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      scan_ff  <= scan_in;
      bnd_ff   <= bnd_in;
      pivot_ff <= pivot_in;
      held_ff  <= held_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### src/qsl_ctrl.sv
// ----------------------------------------------------------------------------
// qsl_ctrl: quicksort sequencer
// Collects the set, walks the range stack, steps each Lomuto partition and
// then streams the sorted store out, one datapath command per cycle.
// ----------------------------------------------------------------------------
module qsl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_stall,
   input  qsl_pkg::stat_type stat,
   output qsl_pkg::op_type   op
);

   typedef enum logic [14:0] {
      S_COLLECT = 15'b000000000000001,
      S_START   = 15'b000000000000010,
      S_POP     = 15'b000000000000100,
      S_DECODE  = 15'b000000000001000,
      S_PIVOT   = 15'b000000000010000,
      S_SCAN    = 15'b000000000100000,
      S_CMP     = 15'b000000001000000,
      S_SW1     = 15'b000000010000000,
      S_SW2     = 15'b000000100000000,
      S_FIN_W1  = 15'b000001000000000,
      S_FIN_W2  = 15'b000010000000000,
      S_PUSH_R  = 15'b000100000000000,
      S_PUSH_L  = 15'b001000000000000,
      S_EMIT_RD = 15'b010000000000000,
      S_EMIT_LD = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = qsl_pkg::OP_IDLE;
      unique case (state_ff)
         S_COLLECT: begin
            if (req_valid) begin
               op = qsl_pkg::OP_LOAD;
               if (req_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            op       = qsl_pkg::OP_START;
            state_in = S_POP;
         end
         S_POP: begin
            if (stat.stack_empty) begin
               state_in = S_EMIT_RD;
            end else begin
               op       = qsl_pkg::OP_POP;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.range_ok) begin
               op       = qsl_pkg::OP_RANGE;
               state_in = S_PIVOT;
            end else begin
               state_in = S_POP;
            end
         end
         S_PIVOT: begin
            op       = qsl_pkg::OP_PIVOT;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               op       = qsl_pkg::OP_FIN_RD;
               state_in = S_FIN_W1;
            end else begin
               op       = qsl_pkg::OP_SCAN_RD;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.le) begin
               op       = qsl_pkg::OP_CMP_HIT;
               state_in = S_SW1;
            end else begin
               op       = qsl_pkg::OP_CMP_MISS;
               state_in = S_SCAN;
            end
         end
         S_SW1: begin
            op       = qsl_pkg::OP_SW1;
            state_in = S_SW2;
         end
         S_SW2: begin
            op       = qsl_pkg::OP_SW2;
            state_in = S_SCAN;
         end
         S_FIN_W1: begin
            op       = qsl_pkg::OP_FIN_W1;
            state_in = S_FIN_W2;
         end
         S_FIN_W2: begin
            op       = qsl_pkg::OP_FIN_W2;
            state_in = S_PUSH_R;
         end
         S_PUSH_R: begin
            op       = qsl_pkg::OP_PUSH_R;
            state_in = S_PUSH_L;
         end
         S_PUSH_L: begin
            op       = qsl_pkg::OP_PUSH_L;
            state_in = S_POP;
         end
         S_EMIT_RD: begin
            if (stat.emit_done) begin
               op       = qsl_pkg::OP_DONE;
               state_in = S_COLLECT;
            end else if (stat.out_free) begin
               op       = qsl_pkg::OP_EMIT_RD;
               state_in = S_EMIT_LD;
            end
         end
         S_EMIT_LD: begin
            op       = qsl_pkg::OP_EMIT_LD;
            state_in = S_EMIT_RD;
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_COLLECT);

endmodule

### src/quicksort_lomuto.sv
// ----------------------------------------------------------------------------
// quicksort_lomuto: collect, sort and stream a set of signed values
// Each request beat carries one 32-bit signed value and a last flag. Values
// are stored one per cycle while req_stall is low; beats beyond MAX_ITEMS are
// dropped, but their last flag still closes the set. req_stall then stays
// high while the set is sorted in place by Lomuto quicksort with a range
// stack, and while the results stream out.
// Sorting is bound by the single-port element store: a scanned element that
// moves left of the boundary costs a swap on top of its read and compare.
// Each response beat is a store read and then an output load; final_res
// marks the last one. A stalled response holds its beat and emission waits.
// The last response may still wait in the output register while the next
// set is being collected.
// Reset empties the store count, the range stack and the output register.
// ----------------------------------------------------------------------------
module quicksort_lomuto #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qsl_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qsl_pkg::rsp_payload_type rsp_payload
);

   qsl_pkg::op_type   op;
   qsl_pkg::stat_type stat;

   qsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last),
      .req_stall (req_stall),
      .stat      (stat),
      .op        (op)
   );

   qsl_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .stat        (stat)
   );

   // A request beat is stored only by the load command.
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (op == qsl_pkg::OP_LOAD))
      else $error("request beat accepted without a store load");

   // The output register must be empty when a sorted value is loaded into it.
   a_emit_into_empty: assert property (@(posedge clock) disable iff (reset)
      (op == qsl_pkg::OP_EMIT_LD) |-> !rsp_valid)
      else $error("sorted value loaded over a pending response");

   // The load uses store data read in the cycle before.
   a_emit_after_read: assert property (@(posedge clock) disable iff (reset)
      (op == qsl_pkg::OP_EMIT_LD) |-> ($past(op) == qsl_pkg::OP_EMIT_RD))
      else $error("emission load without a preceding store read");

   // The second half of a swap always follows the first.
   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      (op == qsl_pkg::OP_SW1) |=> (op == qsl_pkg::OP_SW2))
      else $error("partition swap left half done");

endmodule

### sim/quicksort_lomuto_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quicksort_lomuto_tb: self-checking bench for the quicksort block
// Sends sets of signed values closed by a last flag and predicts the sorted
// stream with its own quicksort over a copy of the stored set. Every response
// beat is checked against the oldest predicted value. Covers single values,
// extremes, duplicates, ordered input, store overflow and long back-pressure.
// ----------------------------------------------------------------------------
module quicksort_lomuto_tb;

   localparam int MAX_SET = 64;
   localparam int STALL_LIMIT = 50000;
   localparam qsl_pkg::data_type DATA_MIN = 32'sh8000_0000;
   localparam qsl_pkg::data_type DATA_MAX = 32'sh7FFF_FFFF;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   qsl_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   qsl_pkg::rsp_payload_type rsp_payload;

   // Predictor state: the set being collected and the sorted values still due.
   qsl_pkg::data_type        held_store [MAX_SET];
   int                       held_count = 0;
   qsl_pkg::rsp_payload_type sorted_expect [$];

   int error_count = 0;
   int values_sent = 0;
   int sets_closed = 0;
   int results_checked = 0;

   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;
   int          receiver_hold_req = 0;
   int          hold_left = 0;
   int          wait_left = 0;
   int unsigned receiver_draw;

   always #5 clock = ~clock;

   quicksort_lomuto #(.MAX_ITEMS(MAX_SET)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Lomuto quicksort over [lo,hi) with an explicit range stack; the pivot is
   // the last element of the range and values equal to it move left.
   function automatic void sort_held_set(int n);
      int                lo_q [$];
      int                hi_q [$];
      int                lo;
      int                hi;
      int                bound;
      qsl_pkg::data_type pivot;
      qsl_pkg::data_type tmp;
      if (n > 1) begin
         lo_q.push_back(0);
         hi_q.push_back(n);
      end
      while (lo_q.size() > 0) begin
         lo = lo_q.pop_back();
         hi = hi_q.pop_back();
         pivot = held_store[hi-1];
         bound = lo;
         for (int s = lo; s < hi - 1; s++) begin
            if (held_store[s] <= pivot) begin
               tmp = held_store[bound];
               held_store[bound] = held_store[s];
               held_store[s] = tmp;
               bound++;
            end
         end
         tmp = held_store[hi-1];
         held_store[hi-1] = held_store[bound];
         held_store[bound] = tmp;
         // The right part goes on the stack first so the left part is done next.
         if (bound + 2 < hi) begin
            lo_q.push_back(bound + 1);
            hi_q.push_back(hi);
         end
         if (lo + 1 < bound) begin
            lo_q.push_back(lo);
            hi_q.push_back(bound);
         end
      end
   endfunction

   function automatic void take_value(qsl_pkg::data_type value, logic last_flag);
      qsl_pkg::rsp_payload_type entry;
      if (held_count < MAX_SET) begin
         held_store[held_count] = value;
         held_count++;
      end
      if (last_flag) begin
         sort_held_set(held_count);
         for (int k = 0; k < held_count; k++) begin
            entry.sorted_value = held_store[k];
            entry.final_res = (k == held_count - 1);
            sorted_expect.push_back(entry);
         end
         held_count = 0;
         sets_closed++;
      end
   endfunction

   function automatic qsl_pkg::data_type random_value();
      case ($urandom_range(0, 7))
         0: return qsl_pkg::data_type'($urandom_range(0, 8)) - 4;
         1: return $urandom_range(0, 1) ? DATA_MIN : DATA_MAX;
         default: return qsl_pkg::data_type'($urandom);
      endcase
   endfunction

   task automatic send_value(qsl_pkg::data_type value, logic last_flag);
      int gap;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.value <= value;
      req_payload.last <= last_flag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      values_sent++;
      take_value(value, last_flag);
   endtask

   task automatic send_set(qsl_pkg::data_type vals [$]);
      foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
   endtask

   // Always waits on the clock before checking, so that valid is written once per step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sorted_expect.size() != 0);
   endtask

   task automatic test_single_value();
      send_value(DATA_MIN, 1'b1);
      send_value(DATA_MAX, 1'b1);
      send_value(random_value(), 1'b1);
      wait_drained();
   endtask

   task automatic test_extremes();
      qsl_pkg::data_type vals [$];
      vals = '{DATA_MAX, DATA_MIN, 32'sd0, -32'sd1, 32'sd1, DATA_MAX, DATA_MIN};
      send_set(vals);
      wait_drained();
   endtask

   task automatic test_duplicates();
      qsl_pkg::data_type vals [$];
      vals = '{32'sd5, 32'sd5, -32'sd7, 32'sd5, 32'sd5};
      send_set(vals);
      wait_drained();
   endtask

   task automatic test_ordered_runs();
      qsl_pkg::data_type vals [$];
      vals = '{-32'sd3, -32'sd1, 32'sd0, 32'sd2, 32'sd7};
      send_set(vals);
      vals = '{32'sd1000, 32'sd10, -32'sd10, -32'sd1000};
      send_set(vals);
      wait_drained();
   endtask

   // Two beats beyond capacity: both values are dropped, the last flag still
   // closes the set.
   task automatic test_store_full();
      for (int i = 0; i < MAX_SET + 2; i++) send_value(random_value(), i == MAX_SET + 1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      sender_idles = 1'b0;
      receiver_hold_req = 300;
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < 6; i++) send_value(random_value(), i == 5);
      end
      wait_drained();
      sender_idles = 1'b1;
   endtask

   task automatic test_random_sets();
      int          set_len;
      int unsigned idle_mode;
      while (values_sent < 155) begin
         idle_mode = $urandom_range(0, 3);
         sender_idles = idle_mode[0];
         receiver_idles = idle_mode[1];
         set_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
         for (int i = 0; i < set_len; i++) send_value(random_value(), i == set_len - 1);
         if ($urandom_range(0, 3) == 0) wait_drained();
      end
   endtask

   // Receiver: a random wait after each accepted beat while receiver_idles is set,
   // or a long hold-off on request from a test.
   always @(posedge clock) begin
      if (receiver_hold_req > 0) begin
         hold_left = receiver_hold_req;
         receiver_hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (wait_left > 0) begin
         wait_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         receiver_draw = receiver_idles ? $urandom_range(0, 5) : 0;
         rsp_stall <= (receiver_draw > 0);
         wait_left = (receiver_draw > 0) ? receiver_draw - 1 : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_expect.size() == 0) begin
            $error("result beat with nothing expected: sorted_value %0d final_res %0b",
                   rsp_payload.sorted_value, rsp_payload.final_res);
            error_count++;
         end else begin
            if (rsp_payload.sorted_value !== sorted_expect[0].sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      sorted_expect[0].sorted_value, rsp_payload.sorted_value);
               error_count++;
            end
            if (rsp_payload.final_res !== sorted_expect[0].final_res) begin
               $error("final_res: expected %0b, actual %0b",
                      sorted_expect[0].final_res, rsp_payload.final_res);
               error_count++;
            end
            void'(sorted_expect.pop_front());
            results_checked++;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no beat moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_single_value();
      test_extremes();
      test_duplicates();
      test_ordered_runs();
      test_store_full();
      test_backpressure();
      test_random_sets();
      wait_drained();
      repeat (100) @(posedge clock);
      $display("Run sorted %0d sets from %0d input beats and checked %0d result beats,",
               sets_closed, values_sent, results_checked);
      $display("with single, extreme, duplicate, ordered, overflowing and held-off sets.");
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
src/qsl_pkg.sv
src/qsl_dp.sv
src/qsl_ctrl.sv
src/quicksort_lomuto.sv
sim/quicksort_lomuto_tb.sv
